### design/deq_pkg.sv
package deq_pkg;

    // Number of entries the queue can hold.
    localparam int CAPACITY = 16;

    // Width of an entry index and of the fill count, which must also hold CAPACITY.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface.
    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 3;
    localparam int ENTRY_W = 5;

    // Operation codes carried on the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_LIST       = 3'd5
    } t_func;

    // What a storage cell takes in on the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PREV = 2'd1,
        CELL_NEXT = 2'd2,
        CELL_LOAD = 2'd3
    } t_cell_op;

endpackage

### design/deq_cell.sv
module deq_cell (
    input  logic                            i_clk,
    input  deq_pkg::t_cell_op               i_op,
    input  logic [deq_pkg::VALUE_W-1:0]     i_prev,
    input  logic [deq_pkg::VALUE_W-1:0]     i_next,
    input  logic [deq_pkg::VALUE_W-1:0]     i_load,
    output logic [deq_pkg::VALUE_W-1:0]     o_data
);

    logic [deq_pkg::VALUE_W-1:0] r_data;

    // One entry of the chain: keep, take from a neighbour, or load a new word.
    always_ff @(posedge i_clk) begin
        case (i_op)
            deq_pkg::CELL_PREV: r_data <= i_prev;
            deq_pkg::CELL_NEXT: r_data <= i_next;
            deq_pkg::CELL_LOAD: r_data <= i_load;
            default:            r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

endmodule

### design/deque_with_search.sv
// Channel   Dir  Handshake              Payload
// s (in)    in   i_s_tvalid/o_s_tready  tdata: value; tuser: func
// m (out)   out  o_m_tvalid/i_m_tready  tdata: out_value, entry_count; tuser: found,
//                                       was_empty, was_full; tlast: is_last
//
// Pushes, pops, undefined codes and any item on an empty queue give one result without a walk.
// A search walks the chain over every entry, then reports; a list delivers one
// item per entry, front first, one per cycle. Both walks rotate the cell chain
// through cell 0, one entry a cycle, and leave it in its original order. A stall
// on the output holds a list at any step and a search only at its final step.
// Reset (synchronous, active low) empties the queue; the cells are not cleared.
module deque_with_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [2:0]  i_s_tuser,   // [2:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] out_value, [36:32] entry_count, zero above
    output logic [2:0]  o_m_tuser,   // [0] found, [1] was_empty, [2] was_full
    output logic        o_m_tlast    // is_last
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    localparam int CAP = deq_pkg::CAPACITY;
    localparam int VW  = deq_pkg::VALUE_W;
    localparam int CW  = deq_pkg::CNT_W;
    localparam int IW  = deq_pkg::IDX_W;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [IW-1:0]          r_step;
    logic                   r_list;
    logic                   r_hit;
    logic [VW-1:0]          r_key;
    logic                   r_out_valid;
    logic [VW-1:0]          r_out_value;
    logic                   r_found;
    logic                   r_empty;
    logic                   r_full;
    logic                   r_last;

    deq_pkg::t_cell_op      cell_op   [CAP];
    logic [VW-1:0]          cell_data [CAP];
    logic [VW-1:0]          load_data;

    logic                   out_free;
    logic                   accept;
    deq_pkg::t_func         func;
    logic                   is_full;
    logic                   is_empty;
    logic [IW-1:0]          last_idx;
    logic                   last_step;
    logic                   advance;
    logic                   match;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign func       = deq_pkg::t_func'(i_s_tuser);
    assign is_full    = (r_count == CW'(CAP));
    assign is_empty   = (r_count == '0);
    assign last_idx   = IW'(r_count - CW'(1));
    assign last_step  = (r_step == last_idx);
    assign match      = (cell_data[0] == r_key);

    // A list step always needs the output; a search only on its final step.
    assign advance    = (r_state == ST_WALK) && ((r_list || last_step) ? out_free : 1'b1);

    // During a walk the front word wraps round to the tail; otherwise a push loads value.
    assign load_data  = (r_state == ST_WALK) ? cell_data[0] : i_s_tdata;

    // Per-cell control derived from the operation and the fill count.
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            cell_op[i] = deq_pkg::CELL_HOLD;
            if (advance) begin
                if (CW'(i) == r_count - CW'(1)) begin
                    cell_op[i] = deq_pkg::CELL_LOAD;
                end else if (CW'(i) < r_count) begin
                    cell_op[i] = deq_pkg::CELL_NEXT;
                end
            end else if (accept) begin
                case (func)
                    deq_pkg::FN_PUSH_FRONT: begin
                        if (!is_full) cell_op[i] = deq_pkg::CELL_PREV;
                    end
                    deq_pkg::FN_PUSH_BACK: begin
                        if (!is_full && CW'(i) == r_count) cell_op[i] = deq_pkg::CELL_LOAD;
                    end
                    deq_pkg::FN_POP_FRONT: begin
                        if (!is_empty) cell_op[i] = deq_pkg::CELL_NEXT;
                    end
                    default: cell_op[i] = deq_pkg::CELL_HOLD;
                endcase
            end
        end
    end

    // The chain of cells, front entry in cell 0.
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        deq_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (cell_op[g]),
            .i_prev ((g == 0) ? i_s_tdata : cell_data[(g == 0) ? 0 : g - 1]),
            .i_next ((g == CAP - 1) ? cell_data[g] : cell_data[(g == CAP - 1) ? g : g + 1]),
            .i_load (load_data),
            .o_data (cell_data[g])
        );
    end

    // Sequencer, fill count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_list      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_out_value <= '0;
                        r_found     <= 1'b0;
                        r_empty     <= 1'b0;
                        r_full      <= 1'b0;
                        r_last      <= 1'b1;
                        r_step      <= '0;
                        r_hit       <= 1'b0;
                        r_key       <= i_s_tdata;
                        r_list      <= (func == deq_pkg::FN_LIST);
                        r_out_valid <= 1'b1;
                        case (func)
                            deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
                                if (is_full) r_full <= 1'b1;
                                else r_count <= r_count + CW'(1);
                            end
                            deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK: begin
                                if (is_empty) r_empty <= 1'b1;
                                else r_count <= r_count - CW'(1);
                            end
                            deq_pkg::FN_SEARCH, deq_pkg::FN_LIST: begin
                                if (is_empty) begin
                                    r_empty <= 1'b1;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_state     <= ST_WALK;
                                end
                            end
                            default: r_last <= 1'b1;
                        endcase
                    end
                end
                ST_WALK: begin
                    if (advance) begin
                        r_step <= r_step + IW'(1);
                        r_hit  <= r_hit || match;
                        if (r_list) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= cell_data[0];
                            r_found     <= 1'b0;
                            r_empty     <= 1'b0;
                            r_full      <= 1'b0;
                            r_last      <= last_step;
                        end else if (last_step) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= '0;
                            r_found     <= r_hit || match;
                            r_empty     <= 1'b0;
                            r_full      <= 1'b0;
                            r_last      <= 1'b1;
                        end
                        if (last_step) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, deq_pkg::ENTRY_W'(r_count), r_out_value};
    assign o_m_tuser  = {r_full, r_empty, r_found};
    assign o_m_tlast  = r_last;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("fill count above capacity");

    // A walk only runs over a non-empty queue.
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_count != '0))
        else $error("walk started on an empty queue");

    // A result never reports both an empty and a full queue.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_empty && r_full))
        else $error("empty and full flagged together");

    // An accepted push into a queue with room adds exactly one entry.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_full && (func == deq_pkg::FN_PUSH_FRONT || func == deq_pkg::FN_PUSH_BACK))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not add an entry");

    // The walk does not change the number of entries.
    a_walk_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |=> (r_count == $past(r_count)))
        else $error("fill count changed during a walk");

endmodule

### dv/tb_deque_with_search.sv
`timescale 1ns / 100ps

// One expected output item, with the fields unpacked.
typedef struct packed {
    logic [deq_pkg::VALUE_W-1:0] value;
    logic                        found;
    logic                        was_empty;
    logic                        was_full;
    logic [deq_pkg::ENTRY_W-1:0] count;
    logic                        last;
} t_deque_result;

// Tracks the queue contents and holds the output items still owed by the block.
class deque_scoreboard;
    logic [deq_pkg::VALUE_W-1:0] ring [deq_pkg::CAPACITY];
    int unsigned                 front;
    int unsigned                 fill;
    t_deque_result               owed_q[$];
    int unsigned                 errors;

    function new();
        front  = 0;
        fill   = 0;
        errors = 0;
    endfunction

    function int unsigned pending();
        return owed_q.size();
    endfunction

    // Queues one expected output item; the count is taken after the operation.
    function void owe(logic [deq_pkg::VALUE_W-1:0] v, logic f, logic e, logic full, logic last);
        t_deque_result r;
        r.value     = v;
        r.found     = f;
        r.was_empty = e;
        r.was_full  = full;
        r.count     = fill[deq_pkg::ENTRY_W-1:0];
        r.last      = last;
        owed_q.push_back(r);
    endfunction

    // Applies one accepted input item and works out the output items it causes.
    function void note_item(logic [deq_pkg::FUNC_W-1:0] fn, logic [deq_pkg::VALUE_W-1:0] val);
        int unsigned i;
        logic        hit;
        hit = 1'b0;
        case (fn) inside
            deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
                if (fill >= deq_pkg::CAPACITY) begin
                    owe('0, 1'b0, 1'b0, 1'b1, 1'b1);
                end else begin
                    if (fn == deq_pkg::FN_PUSH_FRONT) begin
                        front = (front + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
                        ring[front] = val;
                    end else begin
                        ring[(front + fill) % deq_pkg::CAPACITY] = val;
                    end
                    fill++;
                    owe('0, 1'b0, 1'b0, 1'b0, 1'b1);
                end
            end
            deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK: begin
                if (fill == 0) begin
                    owe('0, 1'b0, 1'b1, 1'b0, 1'b1);
                end else begin
                    if (fn == deq_pkg::FN_POP_FRONT)
                        front = (front + 1) % deq_pkg::CAPACITY;
                    fill--;
                    // An emptied queue starts again from slot zero.
                    if (fill == 0)
                        front = 0;
                    owe('0, 1'b0, 1'b0, 1'b0, 1'b1);
                end
            end
            deq_pkg::FN_SEARCH: begin
                if (fill == 0) begin
                    owe('0, 1'b0, 1'b1, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < fill; i++)
                        if (ring[(front + i) % deq_pkg::CAPACITY] == val)
                            hit = 1'b1;
                    owe('0, hit, 1'b0, 1'b0, 1'b1);
                end
            end
            deq_pkg::FN_LIST: begin
                if (fill == 0) begin
                    owe('0, 1'b0, 1'b1, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < fill; i++)
                        owe(ring[(front + i) % deq_pkg::CAPACITY], 1'b0, 1'b0, 1'b0,
                            i + 1 == fill);
                end
            end
            // Unused codes leave the queue alone and only report the count.
            default: owe('0, 1'b0, 1'b0, 1'b0, 1'b1);
        endcase
    endfunction

    // Returns one of the stored values, or any value when the queue is empty.
    function logic [deq_pkg::VALUE_W-1:0] stored_value();
        if (fill == 0)
            return $urandom;
        return ring[(front + $urandom_range(fill - 1)) % deq_pkg::CAPACITY];
    endfunction

    function void compare(string name, logic [deq_pkg::VALUE_W-1:0] exp_v,
                          logic [deq_pkg::VALUE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compares one accepted output item with the oldest one owed.
    function void check_result(logic [39:0] tdata, logic [2:0] tuser, logic tlast);
        t_deque_result r;
        if (owed_q.size() == 0) begin
            $display("%0t: unexpected output item, expected none, actual data %h user %h last %b",
                     $time, tdata, tuser, tlast);
            errors++;
            return;
        end
        r = owed_q.pop_front();
        compare("out_value", r.value, tdata[31:0]);
        compare("entry_count", deq_pkg::VALUE_W'(r.count), deq_pkg::VALUE_W'(tdata[36:32]));
        compare("found", deq_pkg::VALUE_W'(r.found), deq_pkg::VALUE_W'(tuser[0]));
        compare("was_empty", deq_pkg::VALUE_W'(r.was_empty), deq_pkg::VALUE_W'(tuser[1]));
        compare("was_full", deq_pkg::VALUE_W'(r.was_full), deq_pkg::VALUE_W'(tuser[2]));
        compare("is_last", deq_pkg::VALUE_W'(r.last), deq_pkg::VALUE_W'(tlast));
    endfunction
endclass

module tb_deque_with_search;

    // Function codes that the block does not define.
    localparam logic [deq_pkg::FUNC_W-1:0] FN_UNUSED_A = 3'd6;
    localparam logic [deq_pkg::FUNC_W-1:0] FN_UNUSED_B = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 210;
    localparam int unsigned SETTLE_CYCLES = 40;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;    // [31:0] value
    logic [2:0]  i_s_tuser  = '0;    // [2:0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;          // [31:0] out_value, [36:32] entry_count, zero above
    logic [2:0]  o_m_tuser;          // [0] found, [1] was_empty, [2] was_full
    logic        o_m_tlast;          // is_last

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned cycle_count   = 0;
    int unsigned items_noted   = 0;
    int unsigned ops_sent      = 0;

    deque_scoreboard sb = new();

    deque_with_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Both handshakes are observed here, inputs first, then the receiver's ready is redrawn.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_item(i_s_tuser, i_s_tdata);
                items_noted++;
            end
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
        end
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Offers one item, after a random gap, and returns once it has been noted.
    task automatic send_item(input logic [deq_pkg::FUNC_W-1:0] fn,
                             input logic [deq_pkg::VALUE_W-1:0] val);
        int unsigned target;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        target = items_noted + 1;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= val;
        i_s_tuser  <= fn;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        wait (items_noted == target);
        if (fn <= deq_pkg::FN_LIST)
            ops_sent++;
    endtask

    // Holds the input back until every owed output item has arrived, then lets the block settle.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random value with a bias towards the extremes of the signed range.
    function automatic logic [deq_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [deq_pkg::FUNC_W-1:0] any_push();
        return $urandom_range(1) ? deq_pkg::FN_PUSH_BACK : deq_pkg::FN_PUSH_FRONT;
    endfunction

    function automatic logic [deq_pkg::FUNC_W-1:0] any_pop();
        return $urandom_range(1) ? deq_pkg::FN_POP_BACK : deq_pkg::FN_POP_FRONT;
    endfunction

    // Mixes fill bursts, drain bursts, short random runs and a little noise.
    task automatic run_random(input int unsigned target);
        int unsigned kind;
        int unsigned r;
        while (ops_sent < target) begin
            kind = $urandom_range(9);
            if (kind <= 2) begin
                // Fill up, push past full up to twice, then look at the contents.
                while (sb.fill < deq_pkg::CAPACITY)
                    send_item(any_push(), random_value());
                repeat ($urandom_range(2)) send_item(any_push(), random_value());
                if ($urandom_range(1))
                    send_item(deq_pkg::FN_LIST, $urandom);
                else
                    send_item(deq_pkg::FN_SEARCH, sb.stored_value());
            end else if (kind <= 4) begin
                // Drain to empty with the odd search, then touch the empty queue once.
                while (sb.fill > 0) begin
                    if ($urandom_range(4) == 0)
                        send_item(deq_pkg::FN_SEARCH, sb.stored_value());
                    else
                        send_item(any_pop(), $urandom);
                end
                case ($urandom_range(2))
                    0:       send_item(any_pop(), $urandom);
                    1:       send_item(deq_pkg::FN_SEARCH, $urandom);
                    default: send_item(deq_pkg::FN_LIST, $urandom);
                endcase
            end else if (kind <= 8) begin
                repeat (8) begin
                    r = $urandom_range(99);
                    if (r < 40)
                        send_item(any_push(), random_value());
                    else if (r < 65)
                        send_item(any_pop(), $urandom);
                    else if (r < 85)
                        send_item(deq_pkg::FN_SEARCH,
                                  $urandom_range(9) < 7 ? sb.stored_value() : random_value());
                    else
                        send_item(deq_pkg::FN_LIST, $urandom);
                end
            end else begin
                repeat (3) send_item(deq_pkg::FUNC_W'($urandom_range(7)), $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pops, search and list on the empty queue, and the unused codes.
        send_item(deq_pkg::FN_POP_FRONT, $urandom);
        send_item(deq_pkg::FN_POP_BACK, $urandom);
        send_item(deq_pkg::FN_SEARCH, $urandom);
        send_item(deq_pkg::FN_LIST, $urandom);
        send_item(FN_UNUSED_A, $urandom);
        send_item(FN_UNUSED_B, $urandom);

        // Extreme values at both ends, then searches that hit and miss.
        send_item(deq_pkg::FN_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(deq_pkg::FN_PUSH_BACK, 32'h8000_0000);
        send_item(deq_pkg::FN_PUSH_FRONT, 32'h0000_0000);
        send_item(deq_pkg::FN_PUSH_BACK, 32'hFFFF_FFFF);
        send_item(deq_pkg::FN_SEARCH, 32'h8000_0000);
        send_item(deq_pkg::FN_SEARCH, 32'h0000_0005);
        send_item(deq_pkg::FN_LIST, $urandom);
        send_item(deq_pkg::FN_POP_FRONT, $urandom);
        send_item(deq_pkg::FN_POP_BACK, $urandom);
        send_item(FN_UNUSED_A, $urandom);
        send_item(deq_pkg::FN_SEARCH, 32'h7FFF_FFFF);
        send_item(deq_pkg::FN_LIST, $urandom);
        wait_for_results();

        // Random part in four phases of idling on each side.
        ops_sent = 0;
        src_idle_pct = 0;  snk_stall_pct = 0;
        run_random(RANDOM_ITEMS / 4);
        wait_for_results();
        src_idle_pct = 55; snk_stall_pct = 0;
        run_random(RANDOM_ITEMS / 2);
        wait_for_results();
        src_idle_pct = 0;  snk_stall_pct = 55;
        run_random(3 * RANDOM_ITEMS / 4);
        wait_for_results();
        src_idle_pct = 8;  snk_stall_pct = 8;
        run_random(RANDOM_ITEMS);
        wait_for_results();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
